>>> rtl/hsd_pkg.sv
// Shared types, constants and layout functions of the Hamming SEC decoder.
package hsd_pkg;

    localparam int CW_W   = 63;
    localparam int LEN_W  = 6;
    localparam int DATA_W = 57;
    localparam int CHK_W  = 6;
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(3);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_CHECK_ERR = 2'd2,
        ST_BEYOND    = 2'd3
    } t_status;

    typedef struct packed {
        logic [DATA_W-1:0] data_bits;
        logic [LEN_W-1:0]  data_count;
        logic [CHK_W-1:0]  stored_check;
        logic [CHK_W-1:0]  computed_check;
        logic [CHK_W-1:0]  syndrome;
        logic [DATA_W-1:0] corrected_data;
        t_status           status;
    } t_dec_result;

    function automatic bit f_is_pow2(input int v);
        return (v != 0) && ((v & (v - 1)) == 0);
    endfunction

    // Number of powers of two at or below v (elaboration-time form).
    function automatic int f_npow_const(input int v);
        int n;
        n = 0;
        for (int k = 0; k < CHK_W; k++) begin
            if ((1 << k) <= v) n++;
        end
        return n;
    endfunction

    // Same count on a 6-bit signal.
    function automatic logic [2:0] f_npow(input logic [LEN_W-1:0] v);
        logic [2:0] n;
        n = '0;
        for (int k = 0; k < CHK_W; k++) begin
            if (LEN_W'(1 << k) <= v) n = n + 3'd1;
        end
        return n;
    endfunction

    // Data positions covered by check bit k.
    function automatic logic [CW_W-1:0] f_cover_mask(input int k);
        logic [CW_W-1:0] m;
        m = '0;
        for (int p = 1; p <= CW_W; p++) begin
            if (!f_is_pow2(p) && ((p >> k) & 1) == 1) m[p-1] = 1'b1;
        end
        return m;
    endfunction

endpackage

>>> rtl/hsd_in_if.sv
// Input channel: received codeword and its length.
interface hsd_in_if;
    import hsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CW_W-1:0]   codeword;
    logic [LEN_W-1:0]  code_length;

    modport source (output valid, codeword, code_length, input ready);
    modport sink   (input valid, codeword, code_length, output ready);
endinterface

>>> rtl/hsd_out_if.sv
// Output channel: decoded data, check bits, syndrome and status.
interface hsd_out_if;
    import hsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_bits;
    logic [LEN_W-1:0]  data_count;
    logic [CHK_W-1:0]  stored_check;
    logic [CHK_W-1:0]  computed_check;
    logic [CHK_W-1:0]  syndrome;
    logic [DATA_W-1:0] corrected_data;
    logic [1:0]        status;

    modport source (output valid, data_bits, data_count, stored_check, computed_check,
                    syndrome, corrected_data, status, input ready);
    modport sink   (input valid, data_bits, data_count, stored_check, computed_check,
                    syndrome, corrected_data, status, output ready);
endinterface

>>> rtl/hsd_decode.sv
// Combinational decode of one codeword: extraction, parity, syndrome, correction.
module hsd_decode #(
    parameter int MAX_CODE_BITS = 63
) (
    input  logic [hsd_pkg::CW_W-1:0]  i_codeword,
    input  logic [hsd_pkg::LEN_W-1:0] i_code_length,
    output hsd_pkg::t_dec_result      o_result
);
    import hsd_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

    logic [LEN_W-1:0]  len_c;
    logic [CW_W-1:0]   len_mask;
    logic [CW_W-1:0]   mword;
    logic [DATA_W-1:0] data;
    logic [CHK_W-1:0]  stored;
    logic [CHK_W-1:0]  computed;
    logic [CHK_W-1:0]  syn;
    logic [LEN_W-1:0]  idx;
    t_status           status;

    always_comb begin
        if (i_code_length < MIN_LEN) begin
            len_c = MIN_LEN;
        end else if (i_code_length > MAX_LEN) begin
            len_c = MAX_LEN;
        end else begin
            len_c = i_code_length;
        end
    end

    for (genvar gi = 0; gi < CW_W; gi++) begin : g_mask
        assign len_mask[gi] = (LEN_W'(gi) < len_c);
    end

    assign mword = i_codeword & len_mask;

    for (genvar gp = 1; gp <= CW_W; gp++) begin : g_pos
        if (f_is_pow2(gp)) begin : g_chk
            assign stored[$clog2(gp)] = mword[gp-1];
        end else begin : g_dat
            assign data[gp-1-f_npow_const(gp)] = mword[gp-1];
        end
    end

    for (genvar gk = 0; gk < CHK_W; gk++) begin : g_par
        assign computed[gk] = ^(mword & f_cover_mask(gk));
    end

    assign syn = stored ^ computed;
    assign idx = syn - LEN_W'(1) - LEN_W'(f_npow(syn));

    always_comb begin
        if (syn == '0) begin
            status = ST_OK;
        end else if (syn > len_c) begin
            status = ST_BEYOND;
        end else if ((syn & (syn - CHK_W'(1))) == '0) begin
            status = ST_CHECK_ERR;
        end else begin
            status = ST_CORRECTED;
        end
    end

    always_comb begin
        o_result.data_bits      = data;
        o_result.data_count     = len_c - LEN_W'(f_npow(len_c));
        o_result.stored_check   = stored;
        o_result.computed_check = computed;
        o_result.syndrome       = syn;
        o_result.corrected_data = data;
        if (status == ST_CORRECTED) begin
            o_result.corrected_data = data ^ (DATA_W'(1) << idx);
        end
        o_result.status         = status;
    end

endmodule

>>> rtl/hamming_sec_decoder.sv
// Top level of the Hamming single-error-correcting decoder.
//
//  channel  | dir | payload                                        | beat
//  i_in     | in  | codeword, code_length                          | valid & ready
//  o_out    | out | data_bits, data_count, stored/computed_check,  | valid & ready
//           |     | syndrome, corrected_data, status               |
//
//  Path: input register, decode logic, result register, in that order.
//  One codeword per cycle sustained unless o_out stalls; the decode cone (63-bit
//  parity trees, 6-bit syndrome decode) is the only path between both registers.
//  Reset clears both valid flags; payload registers are not reset.
//  A stalled result holds; the input register still loads while it is empty.
module hamming_sec_decoder #(
    parameter int MAX_CODE_BITS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsd_in_if.sink      i_in,
    hsd_out_if.source   o_out
);
    import hsd_pkg::*;

    logic              r_s1_valid;
    logic              n_s1_valid;
    logic [CW_W-1:0]   r_s1_word;
    logic [LEN_W-1:0]  r_s1_len;
    logic              r_out_valid;
    logic              n_out_valid;
    t_dec_result       r_out;
    t_dec_result       dec;
    logic              out_free;
    logic              s1_adv;
    logic              in_beat;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_beat    = i_in.valid && i_in.ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_in.ready) begin
            n_s1_valid = i_in.valid;
        end
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_word <= i_in.codeword;
            r_s1_len  <= i_in.code_length;
        end
        if (s1_adv) begin
            r_out <= dec;
        end
    end

    hsd_decode #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_decode (
        .i_codeword    (r_s1_word),
        .i_code_length (r_s1_len),
        .o_result      (dec)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.data_bits      = r_out.data_bits;
    assign o_out.data_count     = r_out.data_count;
    assign o_out.stored_check   = r_out.stored_check;
    assign o_out.computed_check = r_out.computed_check;
    assign o_out.syndrome       = r_out.syndrome;
    assign o_out.corrected_data = r_out.corrected_data;
    assign o_out.status         = r_out.status;

    a_in_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> r_s1_valid)
        else $error("accepted beat did not load the input register");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1_word) && $stable(r_s1_len))
        else $error("input register lost a pending beat");

    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("decoded beat not captured in result register");

    a_ok_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.status == ST_OK) == (r_out.syndrome == '0)))
        else $error("status disagrees with zero syndrome");

    a_no_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_CORRECTED
            |-> r_out.corrected_data == r_out.data_bits)
        else $error("data changed without a correction");

endmodule

>>> tb/sv/hamming_sec_decoder_tb.sv
// Self-checking testbench of the Hamming SEC decoder: directed table, then random codewords.
module hamming_sec_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsd_pkg::*;

    localparam int MAX_CODE_BITS  = 63;
    localparam int N_DIRECTED     = 19;
    localparam int N_RANDOM       = 1100;
    localparam int HOLD_AT_BEAT   = 320;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic [CW_W-1:0]  cw;
        logic [LEN_W-1:0] len;
        logic             typed;
        t_status          st;
        logic [LEN_W-1:0] cnt;
        logic [CHK_W-1:0] syn;
    } t_vec;

    localparam t_vec DIRECTED_VECS [N_DIRECTED] = '{
        '{63'h0,                   6'd3,  1'b1, ST_OK,        6'd1,  6'd0},
        '{63'h0,                   6'd0,  1'b1, ST_OK,        6'd1,  6'd0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 6'd1,  1'b1, ST_OK,        6'd1,  6'd0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 6'd2,  1'b1, ST_OK,        6'd1,  6'd0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, ST_OK,        6'd57, 6'd0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 6'd62, 1'b1, ST_BEYOND,    6'd56, 6'd63},
        '{63'h7FFF_FFFF_FFFF_FFF8, 6'd3,  1'b1, ST_OK,        6'd1,  6'd0},
        '{63'h4,                   6'd7,  1'b1, ST_CORRECTED, 6'd4,  6'd3},
        '{63'h8,                   6'd7,  1'b1, ST_CHECK_ERR, 6'd4,  6'd4},
        '{63'h1,                   6'd3,  1'b1, ST_CHECK_ERR, 6'd1,  6'd1},
        '{63'h14,                  6'd5,  1'b1, ST_BEYOND,    6'd2,  6'd6},
        '{63'hC,                   6'd6,  1'b1, ST_BEYOND,    6'd3,  6'd7},
        '{63'h4000_0000_0000_0000, 6'd63, 1'b1, ST_CORRECTED, 6'd57, 6'd63},
        '{63'h0000_0000_8000_0000, 6'd63, 1'b1, ST_CHECK_ERR, 6'd57, 6'd32},
        '{63'h0000_0000_C000_0000, 6'd62, 1'b1, ST_BEYOND,    6'd56, 6'd63},
        '{63'h5555_5555_5555_5555, 6'd63, 1'b0, ST_OK,        6'd0,  6'd0},
        '{63'h2AAA_AAAA_AAAA_AAAA, 6'd63, 1'b0, ST_OK,        6'd0,  6'd0},
        '{63'h0123_4567_89AB_CDEF, 6'd40, 1'b0, ST_OK,        6'd0,  6'd0},
        '{63'h7FFF_FFFF_FFFF_FFFF, 6'd32, 1'b0, ST_OK,        6'd0,  6'd0}
    };

    logic i_clk;
    logic i_rst_n;

    hsd_in_if  in_bus();
    hsd_out_if out_bus();

    hamming_sec_decoder #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    t_dec_result pending_results[$];
    int          in_beats;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_dec_result decode_hamming(input logic [CW_W-1:0] cw,
                                                   input logic [LEN_W-1:0] len_in);
        t_dec_result      r;
        int               eff;
        int               dcount;
        int               npow;
        int               idx;
        logic [CHK_W-1:0] syn;
        r      = '0;
        eff    = (len_in < 3) ? 3 : int'(len_in);
        dcount = 0;
        if (eff > MAX_CODE_BITS) eff = MAX_CODE_BITS;
        for (int p = 1; p <= eff; p++) begin
            if ((p & (p - 1)) == 0) begin
                for (int k = 0; k < CHK_W; k++) begin
                    if (p == (1 << k)) r.stored_check[k] = cw[p-1];
                end
            end else begin
                if (dcount < DATA_W) r.data_bits[dcount] = cw[p-1];
                dcount++;
                if (cw[p-1]) r.computed_check = r.computed_check ^ CHK_W'(p);
            end
        end
        syn              = r.stored_check ^ r.computed_check;
        r.syndrome       = syn;
        r.data_count     = LEN_W'(dcount);
        r.corrected_data = r.data_bits;
        if (syn == '0) begin
            r.status = ST_OK;
        end else if (int'(syn) > eff) begin
            r.status = ST_BEYOND;
        end else if ((syn & (syn - 1'b1)) == '0) begin
            r.status = ST_CHECK_ERR;
        end else begin
            npow = 0;
            for (int k = 0; k < CHK_W; k++) begin
                if ((1 << k) <= int'(syn)) npow++;
            end
            idx = int'(syn) - 1 - npow;
            if (idx < DATA_W) r.corrected_data[idx] = ~r.corrected_data[idx];
            r.status = ST_CORRECTED;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic push_codeword(input logic [CW_W-1:0] cw, input logic [LEN_W-1:0] len,
                                 input t_dec_result want);
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.codeword    <= cw;
        in_bus.code_length <= len;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        pending_results.push_back(want);
        in_beats++;
        @(negedge i_clk);
    endtask

    // Result sink with random stalls and one long hold-off.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && in_beats >= HOLD_AT_BEAT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                out_bus.ready <= !(gaps_on && $urandom_range(0, 99) < 21);
            end
        end
    end

    always @(posedge i_clk) begin
        t_dec_result got;
        t_dec_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.data_bits      = out_bus.data_bits;
            got.data_count     = out_bus.data_count;
            got.stored_check   = out_bus.stored_check;
            got.computed_check = out_bus.computed_check;
            got.syndrome       = out_bus.syndrome;
            got.corrected_data = out_bus.corrected_data;
            got.status         = t_status'(out_bus.status);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got.data_bits !== want.data_bits ||
                    got.data_count !== want.data_count ||
                    got.stored_check !== want.stored_check ||
                    got.computed_check !== want.computed_check ||
                    got.syndrome !== want.syndrome ||
                    got.corrected_data !== want.corrected_data ||
                    got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: data %h/%h cnt %0d/%0d stored %h/%h comp %h/%h",
                                 want.data_bits, got.data_bits, want.data_count,
                                 got.data_count, want.stored_check, got.stored_check,
                                 want.computed_check, got.computed_check);
                        $display("          syn %h/%h corr %h/%h status %0d/%0d",
                                 want.syndrome, got.syndrome, want.corrected_data,
                                 got.corrected_data, want.status, got.status);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_dec_result      want;
        logic [CW_W-1:0]  cw;
        logic [LEN_W-1:0] len;
        logic [63:0]      mask;
        int               eff;
        int               pos;
        int               pos2;
        int               sel;
        in_beats           = 0;
        gaps_on            = 1'b1;
        in_bus.valid       = 1'b0;
        in_bus.codeword    = '0;
        in_bus.code_length = '0;
        i_rst_n            = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            want = decode_hamming(DIRECTED_VECS[i].cw, DIRECTED_VECS[i].len);
            if (DIRECTED_VECS[i].typed) begin
                want.status     = DIRECTED_VECS[i].st;
                want.data_count = DIRECTED_VECS[i].cnt;
                want.syndrome   = DIRECTED_VECS[i].syn;
            end
            push_codeword(DIRECTED_VECS[i].cw, DIRECTED_VECS[i].len, want);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            gaps_on = !(i >= 500 && i < 700);
            sel     = $urandom_range(0, 99);
            len     = ($urandom_range(0, 99) < 15) ? LEN_W'(MAX_CODE_BITS)
                                                   : LEN_W'($urandom_range(0, 63));
            eff     = (len < 3) ? 3 : int'(len);
            cw      = CW_W'({$urandom, $urandom});
            if (sel < 70) begin
                // valid codeword of random content, then zero, one or two flips
                mask = (64'd1 << eff) - 64'd1;
                cw   = cw & mask[CW_W-1:0];
                for (int k = 0; k < CHK_W; k++) begin
                    if ((1 << k) <= eff) cw[(1 << k) - 1] = 1'b0;
                end
                want = decode_hamming(cw, len);
                for (int k = 0; k < CHK_W; k++) begin
                    if ((1 << k) <= eff) cw[(1 << k) - 1] = want.computed_check[k];
                end
                if (sel >= 20) begin
                    pos = $urandom_range(1, eff);
                    cw[pos-1] = ~cw[pos-1];
                    if (sel >= 55) begin
                        pos2 = $urandom_range(1, eff);
                        while (pos2 == pos) pos2 = $urandom_range(1, eff);
                        cw[pos2-1] = ~cw[pos2-1];
                    end
                end
            end
            push_codeword(cw, len, decode_hamming(cw, len));
        end
        in_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> hamming_sec_decoder.f
rtl/hsd_pkg.sv
rtl/hsd_in_if.sv
rtl/hsd_out_if.sv
rtl/hsd_decode.sv
rtl/hamming_sec_decoder.sv
tb/sv/hamming_sec_decoder_tb.sv
